// ===== hdl/fita_pkg.sv =====
// ----------------------------------------------------------------------------
// fita_pkg
// Shared constants, codes and types of the file entry / descriptor table.
// ----------------------------------------------------------------------------
package fita_pkg;

    localparam int ENTRIES    = 8;
    localparam int SLOTS      = 32;
    localparam int NAME_BYTES = 8;
    localparam int FIRST_SLOT = 3;   // descriptors 0..2 are reserved

    localparam int NAME_W     = 64;
    localparam int PERM_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int DESC_W     = 5;
    localparam int FREE_W     = 4;

    localparam int ENT_IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_IDX_W = $clog2(SLOTS);

    localparam logic [NAME_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {NAME_W{1'b1}} :
        ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    localparam logic [PERM_W-1:0] PERM_READ = 3'd1;
    localparam logic [PERM_W-1:0] PERM_BOTH = 3'd3;

    typedef enum logic {
        CMD_CREATE = 1'b0,
        CMD_UNLINK = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_NO_ENTRIES = 3'd2,
        ST_EXISTS     = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_SLOTS_FULL = 3'd5
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [DESC_W-1:0]   desc;
        logic [FREE_W-1:0]   free_cnt;
    } t_result;

endpackage

// ===== hdl/file_inode_table_allocator.sv =====
// ----------------------------------------------------------------------------
// file_inode_table_allocator
// Named file entry table with an open-descriptor table: create / unlink.
// ----------------------------------------------------------------------------
//
//  channel   | dir | fields (tdata low bit up)              | tuser
//  ----------+-----+----------------------------------------+-----------
//  s_axis    | in  | name_key[63:0], permission[2:0], pad   | cmd
//  m_axis    | out | status[2:0], descriptor[4:0],          | -
//            |     | free_entries[3:0], pad                 |
//
//  One item per cycle sustained while results drain. A request is held
//  in the input register, is decided there against the tables and
//  commits its table update on the edge that loads the result register.
//  The next request therefore always sees the previous one's effect.
//  Reset (sync, active low) empties both tables, sets the free count to
//  the entry count and drops both valid flags; no clearing pass needed.
//  A stalled result only holds the input register once it is also full.
//
module file_inode_table_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // name_key[63:0], permission[66:64], zero pad
    input  logic        s_axis_tuser,   // cmd (0 create, 1 unlink)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[2:0], descriptor[7:3], free_entries[11:8]
);

    // input register
    logic                          r_in_valid;
    fita_pkg::t_cmd                r_cmd;
    logic [fita_pkg::NAME_W-1:0]   r_key;
    logic [fita_pkg::PERM_W-1:0]   r_perm;

    // result register
    logic                          r_out_valid;
    fita_pkg::t_result             r_out;

    fita_pkg::t_result             res;
    logic                          advance;
    logic                          in_take;

    // request moves on when the result slot is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    fita_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_cmd    (r_cmd),
        .i_key    (r_key),
        .i_perm   (r_perm),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= fita_pkg::t_cmd'(s_axis_tuser);
            r_key  <= s_axis_tdata[63:0];
            r_perm <= s_axis_tdata[66:64];
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.free_cnt, r_out.desc, r_out.status};

    // failed requests never report a descriptor
    a_fail_no_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != fita_pkg::ST_OK)) |-> (r_out.desc == '0))
        else $error("descriptor on failed request");

    // reserved descriptors 1 and 2 are never reported
    a_no_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.desc != fita_pkg::DESC_W'(1) &&
                         r_out.desc != fita_pkg::DESC_W'(2)))
        else $error("reserved descriptor reported");

    // free count never exceeds the table size
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.free_cnt <= fita_pkg::FREE_W'(fita_pkg::ENTRIES)))
        else $error("free count out of range");

    // a result only appears in the cycle after a request advanced
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance))
        else $error("result without request");

endmodule

// ===== hdl/fita_table.sv =====
// ----------------------------------------------------------------------------
// fita_table
// Entry and descriptor tables, one request decided per cycle and committed on i_commit.
// ----------------------------------------------------------------------------
module fita_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  fita_pkg::t_cmd                i_cmd,
    input  logic [fita_pkg::NAME_W-1:0]   i_key,
    input  logic [fita_pkg::PERM_W-1:0]   i_perm,
    output fita_pkg::t_result             o_res
);

    localparam int EQ_W = 2 ** fita_pkg::ENT_IDX_W;

    logic [fita_pkg::NAME_W-1:0]     r_entry_name [fita_pkg::ENTRIES];
    logic [fita_pkg::ENTRIES-1:0]    r_entry_used;
    logic [fita_pkg::SLOTS-1:0]      r_slot_valid;
    logic [fita_pkg::ENT_IDX_W-1:0]  r_slot_entry [fita_pkg::SLOTS];
    logic [fita_pkg::FREE_W-1:0]     r_free_cnt;
    logic [fita_pkg::FREE_W-1:0]     n_free_cnt;

    logic [fita_pkg::NAME_W-1:0]     key;
    logic [EQ_W-1:0]                 eq;
    logic [fita_pkg::ENTRIES-1:0]    hit;
    logic                            found;
    logic                            fe_any;
    logic [fita_pkg::ENT_IDX_W-1:0]  fe_idx;
    logic                            fs_any;
    logic [fita_pkg::SLOT_IDX_W-1:0] fs_idx;
    logic                            ms_any;
    logic [fita_pkg::SLOT_IDX_W-1:0] ms_idx;
    logic                            perm_ok;
    logic                            do_create;
    logic                            do_unlink;
    fita_pkg::t_status               status;
    logic [fita_pkg::DESC_W-1:0]     desc;

    assign key = i_key & fita_pkg::NAME_MASK;

    // name compare on every entry; used bit applied separately
    always_comb begin
        eq = '0;
        for (int e = 0; e < fita_pkg::ENTRIES; e++) begin
            eq[e] = (r_entry_name[e] == key);
        end
    end

    assign hit   = r_entry_used & eq[fita_pkg::ENTRIES-1:0];
    assign found = |hit;

    // lowest unused entry
    always_comb begin
        fe_any = 1'b0;
        fe_idx = '0;
        for (int e = fita_pkg::ENTRIES - 1; e >= 0; e--) begin
            if (!r_entry_used[e]) begin
                fe_any = 1'b1;
                fe_idx = fita_pkg::ENT_IDX_W'(e);
            end
        end
    end

    // lowest free descriptor above the reserved ones
    always_comb begin
        fs_any = 1'b0;
        fs_idx = '0;
        for (int s = fita_pkg::SLOTS - 1; s >= fita_pkg::FIRST_SLOT; s--) begin
            if (!r_slot_valid[s]) begin
                fs_any = 1'b1;
                fs_idx = fita_pkg::SLOT_IDX_W'(s);
            end
        end
    end

    // lowest open descriptor whose entry carries the name
    always_comb begin
        ms_any = 1'b0;
        ms_idx = '0;
        for (int s = fita_pkg::SLOTS - 1; s >= 0; s--) begin
            if (r_slot_valid[s] && eq[r_slot_entry[s]]) begin
                ms_any = 1'b1;
                ms_idx = fita_pkg::SLOT_IDX_W'(s);
            end
        end
    end

    assign perm_ok = (i_perm >= fita_pkg::PERM_READ) && (i_perm <= fita_pkg::PERM_BOTH);

    always_comb begin
        status    = fita_pkg::ST_OK;
        desc      = '0;
        do_create = 1'b0;
        do_unlink = 1'b0;
        case (i_cmd)
            fita_pkg::CMD_CREATE: begin
                if (!perm_ok) begin
                    status = fita_pkg::ST_INVALID;
                end else if (r_free_cnt == '0) begin
                    status = fita_pkg::ST_NO_ENTRIES;
                end else if (found) begin
                    status = fita_pkg::ST_EXISTS;
                end else if (!fe_any) begin
                    status = fita_pkg::ST_NO_ENTRIES;
                end else if (!fs_any) begin
                    status = fita_pkg::ST_SLOTS_FULL;
                end else begin
                    do_create = 1'b1;
                    desc      = fita_pkg::DESC_W'(fs_idx);
                end
            end
            fita_pkg::CMD_UNLINK: begin
                if (!found) begin
                    status = fita_pkg::ST_NOT_FOUND;
                end else if (ms_any) begin
                    do_unlink = 1'b1;
                    desc      = fita_pkg::DESC_W'(ms_idx);
                end
            end
            default: begin
                status = fita_pkg::ST_INVALID;
            end
        endcase
    end

    always_comb begin
        n_free_cnt = r_free_cnt;
        if (do_create) begin
            n_free_cnt = r_free_cnt - 1'b1;
        end else if (do_unlink && (r_free_cnt < fita_pkg::FREE_W'(fita_pkg::ENTRIES))) begin
            n_free_cnt = r_free_cnt + 1'b1;
        end
    end

    assign o_res.status   = status;
    assign o_res.desc     = desc;
    assign o_res.free_cnt = n_free_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_used <= '0;
            r_slot_valid <= '0;
            r_free_cnt   <= fita_pkg::FREE_W'(fita_pkg::ENTRIES);
        end else if (i_commit) begin
            r_free_cnt <= n_free_cnt;
            if (do_create) begin
                r_entry_used[fe_idx] <= 1'b1;
                r_slot_valid[fs_idx] <= 1'b1;
            end
            if (do_unlink) begin
                r_entry_used[r_slot_entry[ms_idx]] <= 1'b0;
                r_slot_valid[ms_idx]               <= 1'b0;
            end
        end
    end

    // names and bindings are only read behind a used / valid bit
    always_ff @(posedge i_clk) begin
        if (i_commit && do_create) begin
            r_entry_name[fe_idx] <= key;
            r_slot_entry[fs_idx] <= fe_idx;
        end
    end

endmodule
